FILE: rtl/core/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared types, constants and helper functions of the byte stream lexer.
// ----------------------------------------------------------------------------
package bsl_pkg;

    localparam int MAX_SOURCE_BYTES = 65536;
    localparam int POS_LIMIT = (MAX_SOURCE_BYTES > 65536) ? 65536 : MAX_SOURCE_BYTES;
    localparam logic [15:0] POS_CAP = 16'(POS_LIMIT - 1);
    localparam logic [15:0] LINE_MAX = 16'hFFFF;

    // results of one item and the result queue
    localparam int MAX_RES   = 3;
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // characters
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_BANG    = 4'd1,
        M_EQUAL   = 4'd2,
        M_GREATER = 4'd3,
        M_LESS    = 4'd4,
        M_SLASH   = 4'd5,
        M_COMMENT = 4'd6,
        M_STRING  = 4'd7,
        M_INT     = 4'd8,
        M_DOT     = 4'd9,
        M_FRAC    = 4'd10
    } t_mode;

    typedef enum logic [4:0] {
        TK_LEFT_PAREN    = 5'd0,
        TK_RIGHT_PAREN   = 5'd1,
        TK_LEFT_BRACE    = 5'd2,
        TK_RIGHT_BRACE   = 5'd3,
        TK_COMMA         = 5'd4,
        TK_DOT           = 5'd5,
        TK_MINUS         = 5'd6,
        TK_PLUS          = 5'd7,
        TK_SEMICOLON     = 5'd8,
        TK_SLASH         = 5'd9,
        TK_STAR          = 5'd10,
        TK_BANG          = 5'd11,
        TK_BANG_EQUAL    = 5'd12,
        TK_EQUAL         = 5'd13,
        TK_EQUAL_EQUAL   = 5'd14,
        TK_GREATER       = 5'd15,
        TK_GREATER_EQUAL = 5'd16,
        TK_LESS          = 5'd17,
        TK_LESS_EQUAL    = 5'd18,
        TK_STRING        = 5'd19,
        TK_NUMBER        = 5'd20,
        TK_EOF           = 5'd21,
        TK_BADCHAR       = 5'd22,
        TK_UNTERM        = 5'd23
    } t_tok_kind;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] tok_start;
        logic [15:0] pos;
        logic [15:0] line;
    } t_lex_state;

    typedef struct packed {
        t_tok_kind   kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } t_token;

    localparam t_lex_state LEX_RESET = '{mode: M_IDLE, tok_start: 16'd0,
                                         pos: 16'd0, line: 16'd1};

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [15:0] span16(input logic [15:0] from, input logic [15:0] upto);
        return (upto > from) ? (upto - from) : 16'd0;
    endfunction

    // span plus one, saturating at the 16-bit limit
    function automatic logic [15:0] len_inc(input logic [15:0] s);
        return (s == 16'hFFFF) ? s : (s + 16'd1);
    endfunction

    function automatic t_tok_kind op_kind(input t_mode m, input logic with_eq);
        t_tok_kind k;
        case (m)
            M_BANG:    k = with_eq ? TK_BANG_EQUAL : TK_BANG;
            M_EQUAL:   k = with_eq ? TK_EQUAL_EQUAL : TK_EQUAL;
            M_GREATER: k = with_eq ? TK_GREATER_EQUAL : TK_GREATER;
            M_LESS:    k = with_eq ? TK_LESS_EQUAL : TK_LESS;
            default:   k = TK_BADCHAR;
        endcase
        return k;
    endfunction

    function automatic t_token make_tok(input t_tok_kind k, input logic [15:0] start,
                                       input logic [15:0] len);
        t_token t;
        t.kind  = k;
        t.start = start;
        t.len   = len;
        t.line  = 16'd0;
        t.last  = 1'b0;
        return t;
    endfunction

endpackage

FILE: rtl/core/bsl_scan.sv
// ----------------------------------------------------------------------------
// bsl_scan
// Lexer step: from the current state and one item, the next state and up to
// three tokens in emission order.
// ----------------------------------------------------------------------------
module bsl_scan (
    input  bsl_pkg::t_lex_state i_state,
    input  logic                i_kind,
    input  logic [7:0]          i_source_byte,
    output bsl_pkg::t_lex_state o_state,
    output logic [1:0]          o_count,
    output bsl_pkg::t_token     o_tok [bsl_pkg::MAX_RES]
);
    import bsl_pkg::*;

    t_token      pre [2];
    logic [1:0]  pre_n;
    t_token      tail;
    logic        tail_en;
    logic        do_idle;
    logic        line_up;
    logic [15:0] sp;
    logic [15:0] dot_pos;
    logic [7:0]  c;
    logic [15:0] p;
    logic [15:0] ts;

    assign c  = i_source_byte;
    assign p  = i_state.pos;
    assign ts = i_state.tok_start;
    assign sp = span16(ts, p);
    // offset of the trailing dot of a number
    assign dot_pos = (p > ts) ? (p - 16'd1) : ts;

    always_comb begin
        o_state = i_state;
        pre[0]  = make_tok(TK_EOF, 16'd0, 16'd0);
        pre[1]  = make_tok(TK_EOF, 16'd0, 16'd0);
        pre_n   = 2'd0;
        tail    = make_tok(TK_EOF, p, 16'd0);
        tail_en = 1'b0;
        do_idle = 1'b0;
        line_up = 1'b0;

        if (i_kind) begin
            // end of source: flush pending token, then eof
            case (i_state.mode)
                M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
                    pre[0] = make_tok(op_kind(i_state.mode, 1'b0), ts, sp);
                    pre_n  = 2'd1;
                end
                M_SLASH: begin
                    pre[0] = make_tok(TK_SLASH, ts, sp);
                    pre_n  = 2'd1;
                end
                M_STRING: begin
                    pre[0] = make_tok(TK_UNTERM, ts, sp);
                    pre_n  = 2'd1;
                end
                M_INT, M_FRAC: begin
                    pre[0] = make_tok(TK_NUMBER, ts, sp);
                    pre_n  = 2'd1;
                end
                M_DOT: begin
                    pre[0] = make_tok(TK_NUMBER, ts, span16(ts, dot_pos));
                    pre[1] = make_tok(TK_DOT, dot_pos, 16'd1);
                    pre_n  = 2'd2;
                end
                default: begin
                    pre_n = 2'd0;
                end
            endcase
            tail_en = 1'b1;
            o_state = LEX_RESET;
        end else begin
            case (i_state.mode)
                M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
                    if (c == CH_EQUAL) begin
                        pre[0]       = make_tok(op_kind(i_state.mode, 1'b1), ts, len_inc(sp));
                        pre_n        = 2'd1;
                        o_state.mode = M_IDLE;
                    end else begin
                        pre[0]  = make_tok(op_kind(i_state.mode, 1'b0), ts, sp);
                        pre_n   = 2'd1;
                        do_idle = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == CH_SLASH) begin
                        o_state.mode = M_COMMENT;
                    end else begin
                        pre[0]  = make_tok(TK_SLASH, ts, sp);
                        pre_n   = 2'd1;
                        do_idle = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (c == CH_NEWLINE) begin
                        line_up      = 1'b1;
                        o_state.mode = M_IDLE;
                    end
                end
                M_STRING: begin
                    if (c == CH_NEWLINE) begin
                        line_up = 1'b1;
                    end
                    if (c == CH_QUOTE) begin
                        pre[0]       = make_tok(TK_STRING, ts, len_inc(sp));
                        pre_n        = 2'd1;
                        o_state.mode = M_IDLE;
                    end
                end
                M_INT: begin
                    if (c == CH_DOT) begin
                        o_state.mode = M_DOT;
                    end else if (!is_digit(c)) begin
                        pre[0]  = make_tok(TK_NUMBER, ts, sp);
                        pre_n   = 2'd1;
                        do_idle = 1'b1;
                    end
                end
                M_DOT: begin
                    if (is_digit(c)) begin
                        o_state.mode = M_FRAC;
                    end else begin
                        pre[0]  = make_tok(TK_NUMBER, ts, span16(ts, dot_pos));
                        pre[1]  = make_tok(TK_DOT, dot_pos, 16'd1);
                        pre_n   = 2'd2;
                        do_idle = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (!is_digit(c)) begin
                        pre[0]  = make_tok(TK_NUMBER, ts, sp);
                        pre_n   = 2'd1;
                        do_idle = 1'b1;
                    end
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase

            if (do_idle) begin
                o_state.tok_start = p;
                o_state.mode      = M_IDLE;
                tail_en           = 1'b1;
                case (c) inside
                    CH_LPAREN:  tail.kind = TK_LEFT_PAREN;
                    CH_RPAREN:  tail.kind = TK_RIGHT_PAREN;
                    CH_LBRACE:  tail.kind = TK_LEFT_BRACE;
                    CH_RBRACE:  tail.kind = TK_RIGHT_BRACE;
                    CH_COMMA:   tail.kind = TK_COMMA;
                    CH_DOT:     tail.kind = TK_DOT;
                    CH_MINUS:   tail.kind = TK_MINUS;
                    CH_PLUS:    tail.kind = TK_PLUS;
                    CH_SEMI:    tail.kind = TK_SEMICOLON;
                    CH_STAR:    tail.kind = TK_STAR;
                    CH_BANG: begin
                        tail_en      = 1'b0;
                        o_state.mode = M_BANG;
                    end
                    CH_EQUAL: begin
                        tail_en      = 1'b0;
                        o_state.mode = M_EQUAL;
                    end
                    CH_GREATER: begin
                        tail_en      = 1'b0;
                        o_state.mode = M_GREATER;
                    end
                    CH_LESS: begin
                        tail_en      = 1'b0;
                        o_state.mode = M_LESS;
                    end
                    CH_SLASH: begin
                        tail_en      = 1'b0;
                        o_state.mode = M_SLASH;
                    end
                    CH_SPACE, CH_CR, CH_TAB: begin
                        tail_en = 1'b0;
                    end
                    CH_NEWLINE: begin
                        tail_en = 1'b0;
                        line_up = 1'b1;
                    end
                    CH_QUOTE: begin
                        tail_en      = 1'b0;
                        o_state.mode = M_STRING;
                    end
                    [CH_ZERO:CH_NINE]: begin
                        tail_en      = 1'b0;
                        o_state.mode = M_INT;
                    end
                    default:    tail.kind = TK_BADCHAR;
                endcase
                tail.len = 16'd1;
            end

            if (line_up && (i_state.line != LINE_MAX)) begin
                o_state.line = i_state.line + 16'd1;
            end
            if (p < POS_CAP) begin
                o_state.pos = p + 16'd1;
            end
        end
    end

    // pending tokens first, the token of the byte itself (or eof) after them
    assign o_count = pre_n + {1'b0, tail_en};

    always_comb begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (2'(i) < pre_n) begin
                o_tok[i] = pre[i % 2];
            end else begin
                o_tok[i] = tail;
            end
            o_tok[i].line = i_state.line;
            o_tok[i].last = (2'(i + 1) == o_count);
        end
    end

endmodule

FILE: rtl/core/bsl_res_fifo.sv
// ----------------------------------------------------------------------------
// bsl_res_fifo
// Small token queue: takes up to three tokens a cycle, hands out one.
// ----------------------------------------------------------------------------
module bsl_res_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_push_cnt,
    input  bsl_pkg::t_token i_tok [bsl_pkg::MAX_RES],
    output logic            o_space,
    output logic            o_valid,
    output bsl_pkg::t_token o_head,
    input  logic            i_pop
);
    import bsl_pkg::*;

    t_token               r_tok [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr;
    logic [RES_PTR_W-1:0] r_rd;
    logic [RES_CNT_W-1:0] r_count;
    logic [RES_PTR_W-1:0] n_wr;
    logic [RES_PTR_W-1:0] n_rd;
    logic [RES_CNT_W-1:0] n_count;
    logic                 pop;

    assign o_valid = (r_count != '0);
    assign o_head  = r_tok[r_rd];
    assign pop     = o_valid && i_pop;
    // room for a full set of tokens, not counting a pop in the same cycle
    assign o_space = (r_count <= RES_CNT_W'(RES_DEPTH - MAX_RES));

    always_comb begin
        n_wr    = r_wr + RES_PTR_W'(i_push_cnt);
        n_rd    = pop ? (r_rd + RES_PTR_W'(1)) : r_rd;
        n_count = r_count + RES_CNT_W'(i_push_cnt) - RES_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (2'(i) < i_push_cnt) begin
                r_tok[r_wr + RES_PTR_W'(i)] <= i_tok[i];
            end
        end
    end

endmodule

FILE: rtl/core/byte_stream_lexer_core.sv
// ----------------------------------------------------------------------------
// byte_stream_lexer_core
// Streaming lexer for Lox-style source text, one byte per cycle while the token queue has room.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_ready carry i_kind (0 source byte, 1 end of
// source) and i_source_byte. Output channel: o_valid / i_ready carry one token
// per transfer; o_last_of_run marks the last token caused by an input item.
// An item is registered on acceptance and scanned once the queue has room for
// a full set, which writes its zero to three tokens into a four-entry token
// queue. Its first token passes through the input register and the token
// queue before it shows on the output.
// Throughput is one item per cycle while items give at most one token each and
// the receiver takes each token; an item giving n tokens holds the single-token
// output port for n transfers, and the scan stage waits with more than one token queued.
// An end-of-source item flushes any pending token, sends eof and returns
// mode, offsets and line count to their reset values for the next source.
// Reset (synchronous, active low) empties the queue and the input register
// and sets line 1, offset 0, idle mode. When the receiver stalls, tokens
// build up in the queue and o_ready falls once it cannot take a full set.
// ----------------------------------------------------------------------------
module byte_stream_lexer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_source_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_start_offset,
    output logic [15:0] o_lexeme_length,
    output logic [15:0] o_line_number,
    output logic        o_last_of_run
);
    import bsl_pkg::*;

    logic       r_in_valid;
    logic       r_in_kind;
    logic [7:0] r_in_byte;
    logic       n_in_valid;
    t_lex_state r_state;
    t_lex_state n_state;
    t_token     step_tok [MAX_RES];
    logic [1:0] step_cnt;
    logic [1:0] push_cnt;
    logic       space;
    logic       fire;
    logic       accept;
    t_token     head;

    assign fire     = r_in_valid && space;
    assign o_ready  = !r_in_valid || fire;
    assign accept   = i_valid && o_ready;
    assign push_cnt = fire ? step_cnt : 2'd0;

    always_comb begin
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= LEX_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (fire) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_source_byte;
        end
    end

    bsl_scan u_scan (
        .i_state       (r_state),
        .i_kind        (r_in_kind),
        .i_source_byte (r_in_byte),
        .o_state       (n_state),
        .o_count       (step_cnt),
        .o_tok         (step_tok)
    );

    bsl_res_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_tok      (step_tok),
        .o_space    (space),
        .o_valid    (o_valid),
        .o_head     (head),
        .i_pop      (i_ready)
    );

    assign o_token_kind    = head.kind;
    assign o_start_offset  = head.start;
    assign o_lexeme_length = head.len;
    assign o_line_number   = head.line;
    assign o_last_of_run   = head.last;

endmodule

FILE: rtl/core/bsl_checker.sv
// ----------------------------------------------------------------------------
// bsl_checker
// Port-level checks of the lexer core, bound to the top level.
// ----------------------------------------------------------------------------
module bsl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_kind,
    input logic [7:0]  i_source_byte,
    input logic        o_valid,
    input logic        i_ready,
    input logic [4:0]  o_token_kind,
    input logic [15:0] o_start_offset,
    input logic [15:0] o_lexeme_length,
    input logic [15:0] o_line_number,
    input logic        o_last_of_run
);
    import bsl_pkg::*;

    // a stalled token holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_token_kind)
            && $stable(o_start_offset) && $stable(o_lexeme_length))
        else $error("token changed while stalled");

    // eof is always the last token of its item and has no length
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == TK_EOF) |-> o_last_of_run && (o_lexeme_length == 16'd0))
        else $error("bad eof token");

    // an unexpected character is one byte and ends its item
    a_badchar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == TK_BADCHAR) |-> o_last_of_run && (o_lexeme_length == 16'd1))
        else $error("bad unexpected-character token");

    // line number is never zero and the token kind is a defined kind
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_line_number != 16'd0) && (o_token_kind <= TK_UNTERM))
        else $error("line number zero or kind out of range");

endmodule

bind byte_stream_lexer_core bsl_checker u_bsl_checker (.*);

FILE: sim/byte_stream_lexer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_lexer_checker
// Watches both channels of the lexer, scans every accepted item with its own
// copy of the lexer state and compares each token sent against the oldest
// token still due. Hands the mismatch count and the number of tokens due up.
// ----------------------------------------------------------------------------
module byte_stream_lexer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_source_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [4:0]  i_token_kind,
    input  logic [15:0] i_start_offset,
    input  logic [15:0] i_lexeme_length,
    input  logic [15:0] i_line_number,
    input  logic        i_last_of_run,
    output int          o_mismatch_count,
    output int          o_tokens_due
);
    import bsl_pkg::*;

    t_mode       cur_mode;
    logic [15:0] tok_start;
    logic [15:0] cur_pos;
    logic [15:0] cur_line;

    t_token tokens_due[$];
    t_token item_tokens[$];
    int     mismatches;

    initial begin
        mismatches       = 0;
        cur_mode         = M_IDLE;
        tok_start        = 16'd0;
        cur_pos          = 16'd0;
        cur_line         = 16'd1;
    end

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic int byte_span(input logic [15:0] from_pos, input logic [15:0] to_pos);
        return (to_pos > from_pos) ? int'(to_pos - from_pos) : 0;
    endfunction

    function automatic t_tok_kind operator_kind(input t_mode m, input logic paired);
        t_tok_kind k;
        case (m)
            M_BANG:    k = paired ? TK_BANG_EQUAL : TK_BANG;
            M_EQUAL:   k = paired ? TK_EQUAL_EQUAL : TK_EQUAL;
            M_GREATER: k = paired ? TK_GREATER_EQUAL : TK_GREATER;
            default:   k = paired ? TK_LESS_EQUAL : TK_LESS;
        endcase
        return k;
    endfunction

    function automatic void add_token(input t_tok_kind k, input logic [15:0] start,
                                      input int len);
        t_token t;
        if (item_tokens.size() >= MAX_RES)
            return;
        t.kind  = k;
        t.start = start;
        t.len   = (len > 65535) ? 16'hFFFF : 16'(len);
        t.line  = cur_line;
        t.last  = 1'b0;
        item_tokens = {item_tokens, t};
    endfunction

    function automatic void bump_line();
        if (cur_line != LINE_MAX)
            cur_line = cur_line + 16'd1;
    endfunction

    // a number followed by a lone dot; p is the offset just past the dot
    function automatic void number_then_dot(input logic [15:0] p);
        logic [15:0] d;
        d = (p > tok_start) ? p - 16'd1 : tok_start;
        add_token(TK_NUMBER, tok_start, byte_span(tok_start, d));
        add_token(TK_DOT, d, 1);
    endfunction

    function automatic void scan_from_idle(input logic [7:0] c, input logic [15:0] p);
        tok_start = p;
        cur_mode  = M_IDLE;
        case (c)
            CH_LPAREN:  add_token(TK_LEFT_PAREN, p, 1);
            CH_RPAREN:  add_token(TK_RIGHT_PAREN, p, 1);
            CH_LBRACE:  add_token(TK_LEFT_BRACE, p, 1);
            CH_RBRACE:  add_token(TK_RIGHT_BRACE, p, 1);
            CH_COMMA:   add_token(TK_COMMA, p, 1);
            CH_DOT:     add_token(TK_DOT, p, 1);
            CH_MINUS:   add_token(TK_MINUS, p, 1);
            CH_PLUS:    add_token(TK_PLUS, p, 1);
            CH_SEMI:    add_token(TK_SEMICOLON, p, 1);
            CH_STAR:    add_token(TK_STAR, p, 1);
            CH_BANG:    cur_mode = M_BANG;
            CH_EQUAL:   cur_mode = M_EQUAL;
            CH_GREATER: cur_mode = M_GREATER;
            CH_LESS:    cur_mode = M_LESS;
            CH_SLASH:   cur_mode = M_SLASH;
            CH_SPACE, CH_CR, CH_TAB: ;
            CH_NEWLINE: bump_line();
            CH_QUOTE:   cur_mode = M_STRING;
            default: begin
                if (digit_char(c))
                    cur_mode = M_INT;
                else
                    add_token(TK_BADCHAR, p, 1);
            end
        endcase
    endfunction

    function automatic void lex_item(input logic is_end, input logic [7:0] c);
        logic [15:0] p;
        t_mode       m;
        p = cur_pos;
        m = cur_mode;
        item_tokens.delete();
        if (is_end) begin
            case (m)
                M_BANG, M_EQUAL, M_GREATER, M_LESS:
                    add_token(operator_kind(m, 1'b0), tok_start, byte_span(tok_start, p));
                M_SLASH:  add_token(TK_SLASH, tok_start, byte_span(tok_start, p));
                M_STRING: add_token(TK_UNTERM, tok_start, byte_span(tok_start, p));
                M_INT, M_FRAC: add_token(TK_NUMBER, tok_start, byte_span(tok_start, p));
                M_DOT:    number_then_dot(p);
                default: ;
            endcase
            add_token(TK_EOF, p, 0);
            // next byte starts a fresh source
            cur_mode  = M_IDLE;
            tok_start = 16'd0;
            cur_pos   = 16'd0;
            cur_line  = 16'd1;
        end else begin
            case (m)
                M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
                    if (c == CH_EQUAL) begin
                        add_token(operator_kind(m, 1'b1), tok_start,
                                  byte_span(tok_start, p) + 1);
                        cur_mode = M_IDLE;
                    end else begin
                        add_token(operator_kind(m, 1'b0), tok_start, byte_span(tok_start, p));
                        scan_from_idle(c, p);
                    end
                end
                M_SLASH: begin
                    if (c == CH_SLASH) begin
                        cur_mode = M_COMMENT;
                    end else begin
                        add_token(TK_SLASH, tok_start, byte_span(tok_start, p));
                        scan_from_idle(c, p);
                    end
                end
                M_COMMENT: begin
                    if (c == CH_NEWLINE) begin
                        bump_line();
                        cur_mode = M_IDLE;
                    end
                end
                M_STRING: begin
                    if (c == CH_NEWLINE)
                        bump_line();
                    if (c == CH_QUOTE) begin
                        add_token(TK_STRING, tok_start, byte_span(tok_start, p) + 1);
                        cur_mode = M_IDLE;
                    end
                end
                M_INT: begin
                    if (c == CH_DOT) begin
                        cur_mode = M_DOT;
                    end else if (!digit_char(c)) begin
                        add_token(TK_NUMBER, tok_start, byte_span(tok_start, p));
                        scan_from_idle(c, p);
                    end
                end
                M_DOT: begin
                    if (digit_char(c)) begin
                        cur_mode = M_FRAC;
                    end else begin
                        number_then_dot(p);
                        scan_from_idle(c, p);
                    end
                end
                M_FRAC: begin
                    if (!digit_char(c)) begin
                        add_token(TK_NUMBER, tok_start, byte_span(tok_start, p));
                        scan_from_idle(c, p);
                    end
                end
                default: scan_from_idle(c, p);
            endcase
            if (cur_pos < POS_CAP)
                cur_pos = cur_pos + 16'd1;
        end
        if (item_tokens.size() > 0)
            item_tokens[item_tokens.size() - 1].last = 1'b1;
        foreach (item_tokens[i])
            tokens_due = {tokens_due, item_tokens[i]};
    endfunction

    always @(posedge i_clk) begin : watch
        t_token want;
        if (!i_rst_n) begin
            tokens_due.delete();
            cur_mode  = M_IDLE;
            tok_start = 16'd0;
            cur_pos   = 16'd0;
            cur_line  = 16'd1;
        end else begin
            // compare before scanning so a token cannot match its own item's prediction
            if (i_out_valid && i_out_ready) begin
                if (tokens_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected token: kind %0d start %0d len %0d line %0d last %0b",
                                 i_token_kind, i_start_offset, i_lexeme_length,
                                 i_line_number, i_last_of_run);
                end else begin
                    want = tokens_due.pop_front();
                    if (i_token_kind !== want.kind || i_start_offset !== want.start ||
                        i_lexeme_length !== want.len || i_line_number !== want.line ||
                        i_last_of_run !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"token mismatch: expected kind %0d start %0d len %0d ",
                                      "line %0d last %0b, got kind %0d start %0d len %0d ",
                                      "line %0d last %0b"},
                                     want.kind, want.start, want.len, want.line, want.last,
                                     i_token_kind, i_start_offset, i_lexeme_length,
                                     i_line_number, i_last_of_run);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                lex_item(i_kind, i_source_byte);
        end
        o_tokens_due     <= tokens_due.size();
        o_mismatch_count <= mismatches;
    end

endmodule

FILE: sim/byte_stream_lexer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_lexer_core_test
// Feeds the lexer a short directed source, a few directed number and
// operator cases, and then random token-shaped source text with random idle
// gaps on both channels. The checker judges every token.
// ----------------------------------------------------------------------------
module byte_stream_lexer_core_test;
    import bsl_pkg::*;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        i_kind        = 1'b0;
    logic [7:0]  i_source_byte = 8'd0;
    logic        i_ready       = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [4:0]  o_token_kind;
    logic [15:0] o_start_offset;
    logic [15:0] o_lexeme_length;
    logic [15:0] o_line_number;
    logic        o_last_of_run;

    int   mismatch_count;
    int   tokens_due;
    int   items_sent = 0;
    int   rx_hold    = 0;
    logic calm       = 1'b0;

    byte_stream_lexer_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_source_byte  (i_source_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_lexeme_length(o_lexeme_length),
        .o_line_number  (o_line_number),
        .o_last_of_run  (o_last_of_run)
    );

    byte_stream_lexer_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_kind          (i_kind),
        .i_source_byte   (i_source_byte),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_token_kind    (o_token_kind),
        .i_start_offset  (o_start_offset),
        .i_lexeme_length (o_lexeme_length),
        .i_line_number   (o_line_number),
        .i_last_of_run   (o_last_of_run),
        .o_mismatch_count(mismatch_count),
        .o_tokens_due    (tokens_due)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // token receiver: after each token it may stall for a random number of cycles
    always @(posedge i_clk) begin : token_sink
        int w;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_hold <= 0;
        end else if (i_ready && o_valid) begin
            w = calm ? 0 : $urandom_range(0, 10);
            if (w != 0) begin
                i_ready <= 1'b0;
                rx_hold <= w;
            end
        end else if (!i_ready) begin
            if (rx_hold <= 1)
                i_ready <= 1'b1;
            else
                rx_hold <= rx_hold - 1;
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] b);
        int w;
        w = calm ? 0 : $urandom_range(0, 10);
        if (w != 0) begin
            i_valid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_source_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(1'b0, b);
    endtask

    task automatic send_end();
        send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // hold the sender off until every token due has come out
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tokens_due != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] punct_char(input int idx);
        logic [7:0] c;
        case (idx)
            0:       c = CH_LPAREN;
            1:       c = CH_RPAREN;
            2:       c = CH_LBRACE;
            3:       c = CH_RBRACE;
            4:       c = CH_COMMA;
            5:       c = CH_DOT;
            6:       c = CH_MINUS;
            7:       c = CH_PLUS;
            8:       c = CH_SEMI;
            9:       c = CH_STAR;
            10:      c = CH_BANG;
            11:      c = CH_EQUAL;
            12:      c = CH_GREATER;
            13:      c = CH_LESS;
            default: c = CH_SLASH;
        endcase
        return c;
    endfunction

    task automatic send_lexeme();
        int         r;
        int         n;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            send_byte(8'($urandom_range(0, 255)));
        end else if (r < 14) begin
            send_end();
        end else if (r < 34) begin
            send_byte(punct_char($urandom_range(0, 14)));
            if ($urandom_range(0, 1) == 1)
                send_byte(CH_EQUAL);
        end else if (r < 50) begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 9) < 4) begin
                send_byte(CH_DOT);
                n = $urandom_range(0, 2);
                repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end else if (r < 62) begin
            send_byte(CH_QUOTE);
            n = $urandom_range(0, 5);
            repeat (n) begin
                b = 8'($urandom_range(32, 126));
                if (b == CH_QUOTE)
                    b = CH_NEWLINE;
                send_byte(b);
            end
            if ($urandom_range(0, 9) < 7)
                send_byte(CH_QUOTE);
        end else if (r < 70) begin
            send_byte(CH_SLASH);
            send_byte(CH_SLASH);
            n = $urandom_range(0, 4);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) < 8)
                send_byte(CH_NEWLINE);
        end else if (r < 85) begin
            case ($urandom_range(0, 3))
                0:       send_byte(CH_SPACE);
                1:       send_byte(CH_CR);
                2:       send_byte(CH_TAB);
                default: send_byte(CH_NEWLINE);
            endcase
        end else begin
            if ($urandom_range(0, 3) == 0)
                send_byte(8'h40);
            else
                send_byte(8'($urandom_range(8'h61, 8'h7A)));
        end
    endtask

    initial begin
        string opening;

        opening = "!=<a//c\n12.+\"\n";
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // operators with lookahead, comment, number-dot-plus, open string at end
        for (int i = 0; i < opening.len(); i++)
            send_byte(opening[i]);
        send_end();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(CH_ZERO + 8'd9);
        send_byte(CH_DOT);
        send_end();
        send_byte(CH_EQUAL);
        send_byte(CH_SLASH);
        send_end();
        drain();

        // fraction, number then dot then letter, operator pair, open slash
        calm <= 1'b1;
        send_byte(CH_ZERO + 8'd1);
        send_byte(CH_DOT);
        send_byte(CH_ZERO + 8'd2);
        send_byte(CH_RPAREN);
        send_byte(CH_ZERO + 8'd5);
        send_byte(CH_DOT);
        send_byte(8'h78);
        send_byte(CH_BANG);
        send_byte(CH_EQUAL);
        send_byte(CH_SLASH);
        send_end();
        calm <= 1'b0;
        drain();

        while (items_sent < 415) begin
            if ($urandom_range(0, 29) == 0)
                calm <= ~calm;
            send_lexeme();
        end
        send_end();
        calm <= 1'b0;

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && tokens_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/bsl_pkg.sv
rtl/core/bsl_scan.sv
rtl/core/bsl_res_fifo.sv
rtl/core/byte_stream_lexer_core.sv
rtl/core/bsl_checker.sv
sim/byte_stream_lexer_checker.sv
sim/byte_stream_lexer_core_test.sv
